[hw/rtl/mbe_pkg.sv]
// Shared types, constants and codes for the Mandelbrot escape pixel unit.
package mbe_pkg;

  localparam int FRAC_BITS = 28;
  localparam int WORD_W    = 32;
  localparam int COUNT_W   = 17;
  localparam int MAXIT_W   = 16;
  localparam int LIMIT_W   = 31;
  localparam int PX_W      = 10;
  localparam int PY_W      = 9;
  localparam int COLOUR_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [MAXIT_W-1:0]   maxit_t;
  typedef logic [LIMIT_W-1:0]   limit_t;
  typedef logic [PX_W-1:0]      px_t;
  typedef logic [PY_W-1:0]      py_t;
  typedef logic [COLOUR_W-1:0]  colour_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MAX_ITER  = 2'd0;
  localparam cfg_idx_t CFG_ESC_LIMIT = 2'd1;

  localparam maxit_t MAX_ITER_RST  = 16'd1000;
  localparam limit_t ESC_LIMIT_RST = 31'h4000_0000;

  localparam colour_t COL_BLACK   = 3'd0;
  localparam colour_t COL_RED     = 3'd1;
  localparam colour_t COL_YELLOW  = 3'd3;
  localparam colour_t COL_BLUE    = 3'd4;
  localparam colour_t COL_MAGENTA = 3'd5;
  localparam colour_t COL_CYAN    = 3'd6;
  localparam colour_t COL_WHITE   = 3'd7;

  typedef struct packed {
    colour_t    colour;
    logic       send_flag;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [5:0] byte2;
  } pack_t;

endpackage

[hw/rtl/mbe_mul.sv]
// Shared fixed-point multiplier with a registered, scaled and truncated product.
module mbe_mul (
  input  logic          clk,
  input  mbe_pkg::word_t op_a,
  input  mbe_pkg::word_t op_b,
  output mbe_pkg::word_t prod
);
  import mbe_pkg::*;

  logic signed [2*WORD_W-1:0] full_prod;
  word_t                      prod_r;

  assign full_prod = $signed(op_a) * $signed(op_b);

  always_ff @(posedge clk) begin
    prod_r <= full_prod[FRAC_BITS+WORD_W-1:FRAC_BITS];
  end

  assign prod = prod_r;

endmodule

[hw/rtl/mbe_pack.sv]
// Colour mapping of the escape count and packing of colour, x and y into bytes.
module mbe_pack (
  input  mbe_pkg::count_t iter_count,
  input  mbe_pkg::maxit_t max_iter,
  input  mbe_pkg::px_t    pixel_x,
  input  mbe_pkg::py_t    pixel_y,
  output mbe_pkg::pack_t  pack
);
  import mbe_pkg::*;

  count_t  mx;
  colour_t colour;

  assign mx = {1'b0, max_iter};

  always_comb begin
    if (iter_count >= mx) begin
      colour = COL_BLACK;
    end else if (iter_count >= (mx >> 1)) begin
      colour = COL_WHITE;
    end else if (iter_count >= (mx >> 2)) begin
      colour = COL_CYAN;
    end else if (iter_count >= (mx >> 3)) begin
      colour = COL_BLUE;
    end else if (iter_count >= (mx >> 4)) begin
      colour = COL_RED;
    end else if (iter_count >= (mx >> 5)) begin
      colour = COL_YELLOW;
    end else if (iter_count >= (mx >> 6)) begin
      colour = COL_MAGENTA;
    end else begin
      colour = COL_RED;
    end
  end

  assign pack.colour    = colour;
  assign pack.send_flag = (colour != COL_BLACK);
  assign pack.byte0     = {pixel_x[4:0], colour};
  assign pack.byte1     = {pixel_y[2:0], pixel_x[9:5]};
  assign pack.byte2     = pixel_y[8:3];

endmodule

[hw/rtl/mandelbrot_escape_pixel_unit.sv]
// Top level: escape-time sequencer around one shared multiplier, with config and output regs.
//
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid/in_tready    c_real, c_imag, pixel_x, pixel_y
// out_     master     out_tvalid/out_tready  iter_count, colour, packet bytes; send flag
// cfg_     slave      cfg_valid/cfg_ready    register index, write data
//
// Each iteration steps through ST_LOOP, ST_XY, ST_RR, ST_II and ST_SQ, because the one
// multiplier forms z_re*z_im, z_re^2 and z_im^2 in turn.
// The synchronous reset restores the iteration limit of 1000 and escape limit of 4.0.
// A new pixel is taken once the previous result sits in the output register;
// a stalled output holds the sequencer only at its final step.
module mandelbrot_escape_pixel_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // c_real[31:0], c_imag[63:32], pixel_x[73:64], pixel_y[82:74], zero fill
  input  logic [mbe_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // iter_count[16:0], colour[19:17], packet_byte0[27:20],
  // packet_byte1[35:28], packet_byte2[41:36], zero fill
  output logic [mbe_pkg::OUT_DATA_W-1:0]      out_tdata,
  // send_flag[0]
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  mbe_pkg::cfg_idx_t                   cfg_index,
  input  mbe_pkg::limit_t                     cfg_data
);
  import mbe_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOOP = 7'b0000010,
    ST_XY   = 7'b0000100,
    ST_RR   = 7'b0001000,
    ST_II   = 7'b0010000,
    ST_SQ   = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  maxit_t max_iter_r;
  limit_t esc_limit_r;
  word_t  c_re_r, c_re_nxt, c_im_r, c_im_nxt;
  px_t    px_r, px_nxt;
  py_t    py_r, py_nxt;
  word_t  zre_r, zre_nxt, zim_r, zim_nxt;
  word_t  zre2_r, zre2_nxt, zim2_r, zim2_nxt;
  count_t count_r, count_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic   out_user_r, out_user_nxt;

  word_t  mul_a, mul_b, mul_p;
  word_t  mag_sum;
  logic   escaped;
  logic   out_load;
  pack_t  pack;

  mbe_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  mbe_pack u_pack (
    .iter_count (count_r),
    .max_iter   (max_iter_r),
    .pixel_x    (px_r),
    .pixel_y    (py_r),
    .pack       (pack)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= MAX_ITER_RST;
      esc_limit_r <= ESC_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_ITER:  max_iter_r  <= cfg_data[MAXIT_W-1:0];
        CFG_ESC_LIMIT: esc_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mul_a = (state_r == ST_II) ? zim_r : zre_r;
  assign mul_b = (state_r == ST_RR) ? zre_r : zim_r;

  assign mag_sum  = zre2_r + mul_p;
  assign escaped  = ($signed(mag_sum) >= $signed({1'b0, esc_limit_r}));
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    c_re_nxt      = c_re_r;
    c_im_nxt      = c_im_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    zre_nxt       = zre_r;
    zim_nxt       = zim_r;
    zre2_nxt      = zre2_r;
    zim2_nxt      = zim2_r;
    count_nxt     = count_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          c_re_nxt  = in_tdata[31:0];
          c_im_nxt  = in_tdata[63:32];
          px_nxt    = in_tdata[73:64];
          py_nxt    = in_tdata[82:74];
          zre_nxt   = '0;
          zim_nxt   = '0;
          zre2_nxt  = '0;
          zim2_nxt  = '0;
          count_nxt = '0;
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (count_r < {1'b0, max_iter_r}) begin
          count_nxt = count_r + 1'b1;
          state_nxt = ST_XY;
        end else begin
          count_nxt = {1'b0, max_iter_r} + 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_XY: begin
        zim_nxt   = {mul_p[WORD_W-2:0], 1'b0} + c_im_r;
        zre_nxt   = zre2_r - zim2_r + c_re_r;
        state_nxt = ST_RR;
      end
      ST_RR: begin
        state_nxt = ST_II;
      end
      ST_II: begin
        zre2_nxt  = mul_p;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        zim2_nxt  = mul_p;
        state_nxt = escaped ? ST_FIN : ST_LOOP;
      end
      ST_FIN: begin
        if (out_load) begin
          out_data_nxt  = {6'd0, pack.byte2, pack.byte1, pack.byte0, pack.colour, count_r};
          out_user_nxt  = pack.send_flag;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_re_r     <= c_re_nxt;
    c_im_r     <= c_im_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    zre_r      <= zre_nxt;
    zim_r      <= zim_nxt;
    zre2_r     <= zre2_nxt;
    zim2_r     <= zim2_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (count_r <= ({1'b0, max_iter_r} + 1'b1)))
    else $error("iteration count exceeds limit plus one");

  a_send_matches_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[19:17] != COL_BLACK)))
    else $error("send flag disagrees with colour");

  a_accept_starts_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_LOOP && count_r == '0))
    else $error("accepted pixel did not start the loop");

  a_escape_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ && escaped) |=> (state_r == ST_FIN))
    else $error("escape did not end the loop");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_FIN))
    else $error("result appeared outside the final step");

endmodule
